/* rtl/core/vbde_pkg.sv */
package vbde_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned BLK_SHIFT   = $clog2(BLOCK_BYTES);

  localparam logic [15:0] ADDR_RESET   = 16'hFFF0;
  localparam logic [15:0] WR_ADDR_BASE = 16'h8000;
  localparam logic [15:0] ECHO_OFFSET  = 16'h4000;
  localparam logic [2:0]  VRAM_PAGE    = 3'b100;  // 0x8000..0x9FFF, not a readable source
  localparam logic [2:0]  ECHO_PAGE    = 3'b111;  // 0xE000..0xFFFF, folded down
  localparam logic [7:0]  OPEN_BUS     = 8'hFF;

  typedef enum logic [2:0] {
    OP_SRC_HI = 3'd0,
    OP_SRC_LO = 3'd1,
    OP_DST_HI = 3'd2,
    OP_DST_LO = 3'd3,
    OP_START  = 3'd4,
    OP_HBLANK = 3'd5,
    OP_COPY   = 3'd6
  } opcode_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] value;
    logic       mode;
    logic [6:0] block_count;
    logic       in_hblank;
    logic       cpu_halted;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_address;
    logic        read_valid;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        copy_request;
    logic        transfer_done;
    logic        hblank_pending;
    logic [6:0]  blocks_left;
  } out_item_t;

endpackage

/* rtl/core/vbde_engine.sv */
module vbde_engine
  import vbde_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [11:0] total_q, total_d;
  logic [11:0] done_q, done_d;
  logic        pend_q, pend_d;
  logic        gen_q, gen_d;
  logic        burst_q, burst_d;

  logic        we;
  logic        xfer_done;
  logic [15:0] waddr;
  logic [7:0]  wdata;
  logic [11:0] remain;
  logic [7:0]  blk_plus1;

  always_comb begin
    src_d     = src_q;
    dst_d     = dst_q;
    total_d   = total_q;
    done_d    = done_q;
    pend_d    = pend_q;
    gen_d     = gen_q;
    burst_d   = burst_q;
    we        = 1'b0;
    xfer_done = 1'b0;
    waddr     = WR_ADDR_BASE;
    wdata     = '0;
    blk_plus1 = {1'b0, item_i.block_count} + 8'd1;

    case (item_i.opcode)
      OP_SRC_HI: src_d = {item_i.value, src_q[7:0]};
      OP_SRC_LO: src_d = {src_q[15:8], item_i.value[7:4], 4'h0};
      OP_DST_HI: dst_d = {item_i.value, dst_q[7:0]};
      OP_DST_LO: dst_d = {dst_q[15:8], item_i.value[7:4], 4'h0};
      OP_START: begin
        total_d = {blk_plus1, {BLK_SHIFT{1'b0}}};
        done_d  = '0;
        gen_d   = 1'b0;
        burst_d = 1'b0;
        if (!item_i.mode) begin
          // general start while a blank transfer waits only cancels it
          pend_d = 1'b0;
          gen_d  = !pend_q;
        end else begin
          pend_d  = 1'b1;
          burst_d = item_i.in_hblank && !item_i.cpu_halted;
        end
      end
      OP_HBLANK: begin
        if (!item_i.cpu_halted && pend_q) burst_d = 1'b1;
      end
      OP_COPY: begin
        if (gen_q || burst_q) begin
          we     = 1'b1;
          waddr  = WR_ADDR_BASE | {3'b000, dst_q[12:0]};
          wdata  = (src_q[15:13] != VRAM_PAGE) ? item_i.value : OPEN_BUS;
          done_d = done_q + 12'd1;
          dst_d  = dst_q + 16'd1;
          src_d  = src_q + 16'd1;
          if (gen_q) begin
            if (done_d >= total_q) begin
              gen_d     = 1'b0;
              xfer_done = 1'b1;
            end
          end else begin
            // block ends on each block boundary or at the transfer end
            if (!(done_d < total_q && done_d[BLK_SHIFT-1:0] != '0)) begin
              if (done_d == total_q) pend_d = 1'b0;
              burst_d   = 1'b0;
              xfer_done = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign remain = total_d - done_d - 12'(BLOCK_BYTES);

  always_comb begin
    res_o = '0;
    if (src_d[15:13] == ECHO_PAGE) res_o.read_address = src_d - ECHO_OFFSET;
    else                           res_o.read_address = src_d;
    res_o.read_valid     = (src_d[15:13] != VRAM_PAGE);
    res_o.write_enable   = we;
    res_o.write_address  = waddr;
    res_o.write_data     = wdata;
    res_o.copy_request   = gen_d || burst_d;
    res_o.transfer_done  = xfer_done;
    res_o.hblank_pending = pend_d;
    res_o.blocks_left    = remain[BLK_SHIFT+6:BLK_SHIFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= ADDR_RESET;
      dst_q   <= ADDR_RESET;
      total_q <= '0;
      done_q  <= '0;
      pend_q  <= 1'b0;
      gen_q   <= 1'b0;
      burst_q <= 1'b0;
    end else if (en_i) begin
      src_q   <= src_d;
      dst_q   <= dst_d;
      total_q <= total_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
      gen_q   <= gen_d;
      burst_q <= burst_d;
    end
  end

  // both runs active at once is impossible
  a_runs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gen_q && burst_q))
    else $error("general and burst runs both active");

  a_done_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_q || burst_q) |-> (done_q < total_q))
    else $error("byte count passed transfer total while running");

  a_burst_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> pend_q)
    else $error("burst running without pending blank transfer");

endmodule

/* rtl/core/vram_block_dma_engine_unit.sv */
// VRAM block DMA engine.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one command beat:
// address byte writes, transfer start, blank entry, or one source data byte.
// Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
// result beat per input beat, in order: mapped source read address, the VRAM
// write made by that beat, run/done/pending flags and the blocks remaining.
// Pipeline: a beat accepted through in_ready_o lands in the input register, its
// result is computed and loaded into the output register once that register is
// free, and is presented from there. Throughput is one beat per cycle while the
// receiver does not stall; the counter and address update between the two registers sets that figure.
// When the receiver stalls, the output register holds its beat and the input
// register holds one more; in_ready_o drops only when both are full.
// Reset clears both pipeline registers and sets the engine to its idle state:
// source and destination 0xFFF0, counts zero, no run active, nothing pending.
module vram_block_dma_engine_unit
  import vbde_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t res;
  logic      out_free;
  logic      s1_adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  vbde_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_item_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  a_adv_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced beat did not reach output register");

  a_done_stops_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.transfer_done) |->
      (out_item_q.write_enable && !out_item_q.copy_request))
    else $error("transfer done without final write or with run still active");

  a_idle_write_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_item_q.write_enable) |->
      (out_item_q.write_address == WR_ADDR_BASE && out_item_q.write_data == 8'h00))
    else $error("write fields set on beat without VRAM write");

  a_write_in_vram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.write_address[15:13] == VRAM_PAGE))
    else $error("write address outside VRAM");

endmodule

/* tb/vram_dma_checker.sv */
module vram_dma_checker
  import vbde_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        results_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // engine state as the predictor sees it
  logic [15:0] src_ptr;
  logic [15:0] dst_addr;
  logic [11:0] byte_total;
  logic [11:0] byte_count;
  logic        blank_pending;
  logic        general_run;
  logic        burst_run;

  out_item_t predicted_q[$];
  out_item_t want;
  int        beat_no;
  bit        bad;

  // only the VRAM page itself cannot be a source
  function automatic logic src_readable(logic [15:0] a);
    return a[15:13] != VRAM_PAGE;
  endfunction

  function automatic out_item_t engine_result(in_item_t beat);
    out_item_t   r;
    logic [11:0] left;
    r = '0;
    r.write_address = WR_ADDR_BASE;
    case (beat.opcode)
      OP_SRC_HI: src_ptr[15:8]  = beat.value;
      OP_SRC_LO: src_ptr[7:0]   = {beat.value[7:4], 4'h0};
      OP_DST_HI: dst_addr[15:8] = beat.value;
      OP_DST_LO: dst_addr[7:0]  = {beat.value[7:4], 4'h0};
      OP_START: begin
        byte_total  = 12'((int'(beat.block_count) + 1) * BLOCK_BYTES);
        byte_count  = '0;
        general_run = 1'b0;
        burst_run   = 1'b0;
        if (!beat.mode) begin
          // general start on top of a pending blank transfer only cancels it
          general_run   = !blank_pending;
          blank_pending = 1'b0;
        end else begin
          blank_pending = 1'b1;
          burst_run     = beat.in_hblank && !beat.cpu_halted;
        end
      end
      OP_HBLANK: begin
        if (blank_pending && !beat.cpu_halted) burst_run = 1'b1;
      end
      OP_COPY: begin
        if (general_run || burst_run) begin
          r.write_enable  = 1'b1;
          r.write_address = WR_ADDR_BASE | {3'b000, dst_addr[12:0]};
          r.write_data    = src_readable(src_ptr) ? beat.value : OPEN_BUS;
          byte_count      = byte_count + 12'd1;
          dst_addr        = dst_addr + 16'd1;
          src_ptr         = src_ptr + 16'd1;
          if (general_run) begin
            if (byte_count >= byte_total) begin
              general_run     = 1'b0;
              r.transfer_done = 1'b1;
            end
          end else if (byte_count >= byte_total || byte_count[BLK_SHIFT-1:0] == '0) begin
            if (byte_count == byte_total) blank_pending = 1'b0;
            burst_run       = 1'b0;
            r.transfer_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.read_address   = (src_ptr[15:13] == ECHO_PAGE) ? src_ptr - ECHO_OFFSET : src_ptr;
    r.read_valid     = src_readable(src_ptr);
    r.copy_request   = general_run || burst_run;
    r.hblank_pending = blank_pending;
    left             = byte_total - byte_count - 12'(BLOCK_BYTES);
    r.blocks_left    = left[BLK_SHIFT +: 7];
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      bad = 1'b1;
      if (fail_count_o < 10)
        $display("result beat %0d %s: expected 0x%0h, got 0x%0h", beat_no, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      src_ptr       = ADDR_RESET;
      dst_addr      = ADDR_RESET;
      byte_total    = '0;
      byte_count    = '0;
      blank_pending = 1'b0;
      general_run   = 1'b0;
      burst_run     = 1'b0;
      beat_no       = 0;
      predicted_q.delete();
    end else begin
      // result side first: a result never belongs to a beat taken at this edge
      if (out_valid_i && out_ready_i) begin
        if (predicted_q.size() == 0) begin
          if (fail_count_o < 10) $display("result beat %0d arrived with none owed", beat_no);
          fail_count_o++;
        end else begin
          want = predicted_q.pop_front();
          bad  = 1'b0;
          check_field("read_address", want.read_address, out_data_i.read_address);
          check_field("read_valid", 16'(want.read_valid), 16'(out_data_i.read_valid));
          check_field("write_enable", 16'(want.write_enable), 16'(out_data_i.write_enable));
          check_field("write_address", want.write_address, out_data_i.write_address);
          check_field("write_data", 16'(want.write_data), 16'(out_data_i.write_data));
          check_field("copy_request", 16'(want.copy_request), 16'(out_data_i.copy_request));
          check_field("transfer_done", 16'(want.transfer_done),
                      16'(out_data_i.transfer_done));
          check_field("hblank_pending", 16'(want.hblank_pending),
                      16'(out_data_i.hblank_pending));
          check_field("blocks_left", 16'(want.blocks_left), 16'(out_data_i.blocks_left));
          if (bad) fail_count_o++;
        end
        beat_no++;
      end
      if (in_valid_i && in_ready_i) predicted_q.push_back(engine_result(in_data_i));
    end
    results_owed_o = predicted_q.size();
  end

endmodule

/* tb/tb_vram_block_dma_engine_unit.sv */
module tb_vram_block_dma_engine_unit import vbde_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED      = 3'd7;
  localparam int         BEAT_GOAL      = 1800;
  localparam int         DRAIN_EVERY    = 450;
  localparam int         HOLD_CYCLES    = 64;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int results_owed;
  int work_beats;
  int quiet_cycles;
  int next_drain;
  bit hold_off_req;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  vram_block_dma_engine_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  vram_dma_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .fail_count_o  (fail_count),
    .results_owed_o(results_owed)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_blocks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 2);
    if (r < 96) return $urandom_range(3, 7);
    return $urandom_range(8, 31);
  endfunction

  // fields the opcode does not use still get random content
  function automatic in_item_t noisy_beat(logic [2:0] op, logic [7:0] val);
    in_item_t b;
    b.opcode      = op;
    b.value       = val;
    b.mode        = 1'($urandom);
    b.block_count = 7'($urandom);
    b.in_hblank   = 1'($urandom);
    b.cpu_halted  = 1'($urandom);
    return b;
  endfunction

  function automatic in_item_t stray_beat();
    return noisy_beat(3'($urandom_range(0, 7)), 8'($urandom));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(in_item_t b);
    int gap;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (!in_ready);
    if (b.opcode != OP_UNUSED) work_beats++;
    if (work_beats % 600 == 20) hold_off_req = 1'b1;
    @(negedge clk_i);
    // back-to-back window so the receiver hold-off backs the block up
    gap = (work_beats % 600 < 120) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (results_owed != 0) @(negedge clk_i);
  endtask

  task automatic copy_beats(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 299) == 0) break;
      if ($urandom_range(0, 49) == 0) send_beat(stray_beat());
      send_beat(noisy_beat(OP_COPY, 8'($urandom)));
    end
  endtask

  task automatic run_transfer();
    in_item_t b;
    int       blocks;
    if ($urandom_range(0, 3) != 0) send_beat(noisy_beat(OP_SRC_HI, 8'($urandom)));
    if ($urandom_range(0, 3) != 0) send_beat(noisy_beat(OP_SRC_LO, 8'($urandom)));
    if ($urandom_range(0, 3) != 0) send_beat(noisy_beat(OP_DST_HI, 8'($urandom)));
    if ($urandom_range(0, 3) != 0) send_beat(noisy_beat(OP_DST_LO, 8'($urandom)));
    blocks        = pick_blocks();
    b             = noisy_beat(OP_START, 8'($urandom));
    b.block_count = 7'(blocks);
    b.cpu_halted  = ($urandom_range(0, 3) == 0);
    send_beat(b);
    if (!b.mode) begin
      copy_beats((blocks + 1) * BLOCK_BYTES);
    end else begin
      for (int k = 0; k <= blocks; k++) begin
        b            = noisy_beat(OP_HBLANK, 8'($urandom));
        b.cpu_halted = ($urandom_range(0, 3) == 0);
        send_beat(b);
        // halted CPU blocks the trigger, so offer the blank again
        if (b.cpu_halted) begin
          b.cpu_halted = 1'b0;
          send_beat(b);
        end
        copy_beats(BLOCK_BYTES);
        if ($urandom_range(0, 39) == 0) break;
      end
    end
  endtask

  initial begin : receiver
    int n;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
        repeat (n) @(negedge clk_i);
        n = idle_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    in_item_t b;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    hold_off_req = 1'b0;
    work_beats   = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unused opcode, stray copy and stray blank with nothing set up
    send_beat('1);
    send_beat(noisy_beat(OP_COPY, 8'hAB));
    send_beat(noisy_beat(OP_HBLANK, 8'h00));
    // echo-region source wrapping to zero, destination crossing out of VRAM
    send_beat(noisy_beat(OP_SRC_HI, 8'hFF));
    send_beat(noisy_beat(OP_SRC_LO, 8'hFF));
    send_beat(noisy_beat(OP_DST_HI, 8'h9F));
    send_beat(noisy_beat(OP_DST_LO, 8'hFF));
    b             = noisy_beat(OP_START, 8'h00);
    b.mode        = 1'b0;
    b.block_count = '0;
    send_beat(b);
    for (int i = 0; i < BLOCK_BYTES; i++)
      send_beat(noisy_beat(OP_COPY, i[0] ? 8'hFF : 8'h00));
    // longest blank transfer started inside a blank, then cancelled
    b             = noisy_beat(OP_START, 8'h00);
    b.mode        = 1'b1;
    b.block_count = '1;
    b.in_hblank   = 1'b1;
    b.cpu_halted  = 1'b0;
    send_beat(b);
    b.mode        = 1'b0;
    b.block_count = '0;
    send_beat(b);
    wait_drained();

    next_drain = DRAIN_EVERY;
    while (work_beats < BEAT_GOAL) begin
      run_transfer();
      if ($urandom_range(0, 4) == 0) send_beat(stray_beat());
      if (work_beats >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_EVERY;
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && results_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
